// ----- rtl/core/sls_pkg.sv -----
// ----------------------------------------------------------------------------
// Soft limiter package
// Shared constants, codes and types of the stereo look-ahead soft limiter.
// ----------------------------------------------------------------------------
package sls_pkg;

    localparam int FRAME_DEPTH  = 64;
    localparam int SAMPLE_WIDTH = 24;
    localparam int ADDR_W       = $clog2(FRAME_DEPTH);
    localparam int CNT_W        = $clog2(FRAME_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Divider operand widths.
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = SAMPLE_WIDTH + 16;

    // Datapath widths.
    localparam int SG_W = SAMPLE_WIDTH + 17;
    localparam int D_W  = SAMPLE_WIDTH + 18;
    localparam int PK_W = SAMPLE_WIDTH + 33;
    localparam int PL_W = 43;
    localparam int PH_W = 18 + D_W - 24;
    localparam int X_W  = SAMPLE_WIDTH + 40;

    localparam logic [31:0] K_MAX = 32'h8000_0000;
    localparam logic [16:0] A_MAX = 17'h1_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_L,
        CFG_GAIN_R,
        CFG_LIMIT,
        CFG_RELEASE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SIGN_NONE,
        SIGN_POS,
        SIGN_NEG
    } t_sign;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE_RD,
        S_PRE_L,
        S_PRE_R,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_RD,
        S_MUL1,
        S_MUL2,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        JOB_KC,
        JOB_KP,
        JOB_FIT
    } t_job;

    typedef enum logic [1:0] {
        MODE_GAIN,
        MODE_FIT,
        MODE_KP,
        MODE_KC
    } t_mode;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

// ----- rtl/core/sls_in_if.sv -----
// ----------------------------------------------------------------------------
// Soft limiter input channel
// Valid/ready channel carrying one stereo input word or a stream command.
// ----------------------------------------------------------------------------
interface sls_in_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       command;
    logic signed [sls_pkg::SAMPLE_WIDTH-1:0]    left_sample;
    logic signed [sls_pkg::SAMPLE_WIDTH-1:0]    right_sample;
    logic                                       last_frame;

    modport source (
        output valid, command, left_sample, right_sample, last_frame,
        input  ready
    );
    modport sink (
        input  valid, command, left_sample, right_sample, last_frame,
        output ready
    );
endinterface

// ----- rtl/core/sls_out_if.sv -----
// ----------------------------------------------------------------------------
// Soft limiter output channel
// Valid/ready channel carrying one limited stereo output word.
// ----------------------------------------------------------------------------
interface sls_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               last_out;

    modport source (
        output valid, left_out, right_out, last_out,
        input  ready
    );
    modport sink (
        input  valid, left_out, right_out, last_out,
        output ready
    );
endinterface

// ----- rtl/core/sls_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sls_div.sv -----
// ----------------------------------------------------------------------------
// Soft limiter divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sls_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sls_pkg::t_div_req i_req,
    output sls_pkg::t_div_rsp o_rsp
);

    logic                               r_busy;
    logic                               r_done;
    logic [$clog2(sls_pkg::DIV_NUM_W)-1:0] r_cnt;
    logic [sls_pkg::DIV_DEN_W:0]        r_rem;
    logic [sls_pkg::DIV_NUM_W-1:0]      r_quo;
    logic [sls_pkg::DIV_DEN_W-1:0]      r_den;

    logic [sls_pkg::DIV_DEN_W:0]        rem_sh;
    logic [sls_pkg::DIV_DEN_W:0]        rem_nx;
    logic                               ge;

    always_comb begin
        rem_sh = {r_rem[sls_pkg::DIV_DEN_W-1:0], r_quo[sls_pkg::DIV_NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        rem_nx = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= rem_nx;
                r_quo <= {r_quo[sls_pkg::DIV_NUM_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(sls_pkg::DIV_NUM_W))'(sls_pkg::DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ----- rtl/core/stereo_lookahead_soft_limiter.sv -----
// ----------------------------------------------------------------------------
// Stereo look-ahead soft limiter
// Frames are taken one per cycle into a frame RAM while each channel's peak,
// zero crossing and held peak are tracked. A chunk closes at a word marked
// last, or when the 64-entry RAM is full. The block then reads the sample at
// each channel's peak, runs up to six divisions (crossing gain, peak gain and
// fit slope per channel) through one shared bit-serial divider, and finally
// reads the chunk back frame by frame through the states S_RD, S_MUL1, S_MUL2,
// S_FIN and S_OUT, giving one limited word per frame. No input is taken while
// a chunk is being set up or emitted. A command word clamps the held peaks to
// the limit, clears the tails and drops any partly buffered chunk without
// output.
// ----------------------------------------------------------------------------
module stereo_lookahead_soft_limiter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sls_in_if.sink                            i_in,
    sls_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [sls_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sls_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Configuration registers.
    logic [15:0] r_gain [2];
    logic [14:0] r_limit;
    logic [15:0] r_rel;

    // Per-channel tracking state.
    logic [31:0]                    r_held  [2];
    logic [31:0]                    r_local [2];
    logic                           r_pp_vld [2];
    logic [sls_pkg::ADDR_W-1:0]     r_pp     [2];
    logic                           r_cp_vld [2];
    logic [sls_pkg::ADDR_W-1:0]     r_cp     [2];
    sls_pkg::t_sign                 r_prev   [2];
    logic signed [15:0]             r_tail   [2];

    // Sequencer.
    sls_pkg::t_state                r_state, n_state;
    logic [sls_pkg::CNT_W-1:0]      r_cnt;
    logic [sls_pkg::ADDR_W-1:0]     r_i;
    sls_pkg::t_job                  r_job;
    logic                           r_jch;

    // Per-chunk coefficients.
    logic [sls_pkg::SAMPLE_WIDTH-1:0] r_sp [2];
    logic [31:0]                    r_kc [2];
    logic [31:0]                    r_kp [2];
    logic signed [17:0]             r_a  [2];

    // Output pipeline.
    sls_pkg::t_mode                 r_mode [2];
    logic signed [sls_pkg::PK_W-1:0] r_pk [2];
    logic signed [sls_pkg::SG_W-1:0] r_pg [2];
    logic signed [sls_pkg::PL_W-1:0] r_pl [2];
    logic signed [sls_pkg::PH_W-1:0] r_ph [2];
    logic signed [15:0]             r_out [2];
    logic                           r_out_last;

    // Frame RAM.
    logic                                 ram_we;
    logic [sls_pkg::ADDR_W-1:0]           ram_raddr;
    logic [2*sls_pkg::SAMPLE_WIDTH-1:0]   ram_rdata;

    // Divider.
    sls_pkg::t_div_req div_req;
    sls_pkg::t_div_rsp div_rsp;

    // Handshake decode.
    logic in_acc, frame_acc, cmd_acc, out_acc, chunk_end, first, last_i;
    logic [sls_pkg::CNT_W-1:0]  cnt_nx;
    logic [sls_pkg::ADDR_W-1:0] idx;
    logic [22:0]                bound;

    // Scan of the incoming frame.
    logic signed [sls_pkg::SAMPLE_WIDTH-1:0] s_in [2];
    logic [sls_pkg::SAMPLE_WIDTH-1:0]   s_mag  [2];
    logic [sls_pkg::SAMPLE_WIDTH+15:0]  v_full [2];
    logic [31:0]                        v      [2];
    logic [31:0]                        b_local [2];
    logic                               b_pp_vld [2];
    logic                               b_cp_vld [2];
    sls_pkg::t_sign                     b_prev  [2];
    sls_pkg::t_sign                     sg      [2];
    logic [31:0]                        sc_local [2];
    logic                               sc_pp_set [2];
    logic                               sc_cp_set [2];
    logic [31:0]                        sc_held  [2];

    // Division set-up for the channel in hand.
    logic [15:0]                        j_tmag;
    logic [23:0]                        j_t;
    logic [sls_pkg::SAMPLE_WIDTH+15:0]  j_spg;
    logic [sls_pkg::SAMPLE_WIDTH+16:0]  j_d;
    logic                               j_dpos;
    logic [24:0]                        j_bmt;
    logic                               j_neg;
    logic [23:0]                        j_abmt;
    logic [30:0]                        j_gl;
    logic                               j_need;
    logic                               j_last;
    logic                               j_adv;
    logic [31:0]                        q_k;
    logic [16:0]                        q_a;

    // Output pipeline combinational values.
    logic signed [sls_pkg::SAMPLE_WIDTH-1:0] s_rd [2];
    sls_pkg::t_mode                     m_sel [2];
    logic signed [sls_pkg::D_W-1:0]     d_fit [2];
    logic signed [15:0]                 f_out [2];

    // Truncation toward zero of the selected product, then 16-bit saturation.
    function automatic logic signed [15:0] fin_value(
        input sls_pkg::t_mode                  m,
        input logic signed [sls_pkg::PK_W-1:0] pk,
        input logic signed [sls_pkg::SG_W-1:0] pg,
        input logic signed [sls_pkg::PL_W-1:0] pl,
        input logic signed [sls_pkg::PH_W-1:0] ph,
        input logic signed [15:0]              tail
    );
        logic signed [sls_pkg::X_W-1:0] x;
        logic signed [sls_pkg::X_W-1:0] q;
        logic                           rnd;
        case (m)
            sls_pkg::MODE_FIT: begin
                x   = (sls_pkg::X_W'(ph) <<< 24) + sls_pkg::X_W'(pl)
                    + (sls_pkg::X_W'(tail) <<< 24);
                q   = x >>> 24;
                rnd = x[sls_pkg::X_W-1] && (x[23:0] != '0);
            end
            sls_pkg::MODE_KP, sls_pkg::MODE_KC: begin
                x   = sls_pkg::X_W'(pk);
                q   = x >>> 16;
                rnd = x[sls_pkg::X_W-1] && (x[15:0] != '0);
            end
            default: begin
                x   = sls_pkg::X_W'(pg);
                q   = x >>> 8;
                rnd = x[sls_pkg::X_W-1] && (x[7:0] != '0);
            end
        endcase
        q = q + $signed({{(sls_pkg::X_W-1){1'b0}}, rnd});
        if (q > 32767) begin
            return 16'sh7FFF;
        end else if (q < -32768) begin
            return -16'sh8000;
        end
        return q[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Handshake decode
    // ------------------------------------------------------------------
    assign in_acc    = i_in.valid & i_in.ready;
    assign frame_acc = in_acc & ~i_in.command;
    assign cmd_acc   = in_acc & i_in.command;
    assign out_acc   = o_out.valid & o_out.ready;
    assign idx       = r_cnt[sls_pkg::ADDR_W-1:0];
    assign cnt_nx    = r_cnt + 1'b1;
    assign first     = (r_cnt == '0);
    assign chunk_end = frame_acc
                     & (i_in.last_frame | (cnt_nx == sls_pkg::CNT_W'(sls_pkg::FRAME_DEPTH)));
    assign bound     = {r_limit, 8'h00};
    assign last_i    = ((sls_pkg::CNT_W'(r_i) + 1'b1) == r_cnt);
    assign s_in[0]   = i_in.left_sample;
    assign s_in[1]   = i_in.right_sample;

    // ------------------------------------------------------------------
    // Scan: each channel's peak, crossing and held peak for the new frame.
    // The first frame of a chunk starts from the held peak, with no peak,
    // crossing or previous sign recorded.
    // ------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            s_mag[c]  = s_in[c][sls_pkg::SAMPLE_WIDTH-1] ? sls_pkg::SAMPLE_WIDTH'(-s_in[c])
                                                         : sls_pkg::SAMPLE_WIDTH'(s_in[c]);
            v_full[c] = (sls_pkg::SAMPLE_WIDTH+16)'(s_mag[c])
                      * (sls_pkg::SAMPLE_WIDTH+16)'(r_gain[c]);
            v[c]      = (v_full[c][sls_pkg::SAMPLE_WIDTH+15:32] != '0) ? 32'hFFFF_FFFF
                                                                       : v_full[c][31:0];
            b_local[c]  = first ? r_held[c] : r_local[c];
            b_pp_vld[c] = first ? 1'b0 : r_pp_vld[c];
            b_cp_vld[c] = first ? 1'b0 : r_cp_vld[c];
            b_prev[c]   = first ? sls_pkg::SIGN_NONE : r_prev[c];
            sg[c]       = s_in[c][sls_pkg::SAMPLE_WIDTH-1] ? sls_pkg::SIGN_NEG
                                                           : sls_pkg::SIGN_POS;
            sc_local[c]  = b_local[c];
            sc_pp_set[c] = 1'b0;
            if ((v[c] > 32'(bound)) && (v[c] > b_local[c])) begin
                sc_local[c]  = v[c];
                sc_pp_set[c] = ~b_cp_vld[c];
            end
            sc_held[c]   = (v[c] > r_held[c]) ? v[c] : r_held[c];
            sc_cp_set[c] = ~b_cp_vld[c] && (b_prev[c] != sls_pkg::SIGN_NONE)
                         && (b_prev[c] != sg[c]);
        end
    end

    // ------------------------------------------------------------------
    // Division set-up. Jobs run in the order crossing gain, peak gain, fit
    // slope, for the left channel and then the right. A job whose result
    // cannot be used, or whose divisor is not positive, yields zero.
    // ------------------------------------------------------------------
    always_comb begin
        j_tmag = r_tail[r_jch][15] ? 16'(-r_tail[r_jch]) : r_tail[r_jch];
        j_t    = {j_tmag, 8'h00};
        j_spg  = (sls_pkg::SAMPLE_WIDTH+16)'(r_sp[r_jch])
               * (sls_pkg::SAMPLE_WIDTH+16)'(r_gain[r_jch]);
        j_d    = {1'b0, j_spg} - (sls_pkg::SAMPLE_WIDTH+17)'(j_t);
        j_dpos = ~j_d[sls_pkg::SAMPLE_WIDTH+16] && (j_d != '0);
        j_bmt  = {2'b00, bound} - {1'b0, j_t};
        j_neg  = j_bmt[24];
        j_abmt = j_neg ? 24'(-j_bmt) : j_bmt[23:0];
        j_gl   = 31'(r_gain[r_jch]) * 31'(r_limit);

        div_req.num = '0;
        div_req.den = '0;
        j_need      = 1'b0;
        case (r_job)
            sls_pkg::JOB_KC: begin
                j_need      = (r_held[r_jch] != '0);
                div_req.num = sls_pkg::DIV_NUM_W'({j_gl, 16'h0000});
                div_req.den = sls_pkg::DIV_DEN_W'(r_held[r_jch]);
            end
            sls_pkg::JOB_KP: begin
                j_need      = r_pp_vld[r_jch];
                div_req.num = sls_pkg::DIV_NUM_W'({r_limit, 16'h0000});
                div_req.den = sls_pkg::DIV_DEN_W'(r_sp[r_jch]);
            end
            sls_pkg::JOB_FIT: begin
                j_need      = r_pp_vld[r_jch] & j_dpos;
                div_req.num = sls_pkg::DIV_NUM_W'({j_abmt, 16'h0000});
                div_req.den = j_d[sls_pkg::SAMPLE_WIDTH+15:0];
            end
            default: begin
                j_need = 1'b0;
            end
        endcase
        div_req.start = (r_state == sls_pkg::S_DIV_LOAD) && j_need;

        j_last = (r_job == sls_pkg::JOB_FIT) && r_jch;
        j_adv  = ((r_state == sls_pkg::S_DIV_LOAD) && !j_need)
               || ((r_state == sls_pkg::S_DIV_RUN) && div_rsp.done);

        // Gains beyond 2^31 saturate every non-zero sample anyway.
        q_k = (div_rsp.quo > sls_pkg::DIV_NUM_W'(sls_pkg::K_MAX)) ? sls_pkg::K_MAX
                                                                 : div_rsp.quo[31:0];
        q_a = (div_rsp.quo > sls_pkg::DIV_NUM_W'(sls_pkg::A_MAX)) ? sls_pkg::A_MAX
                                                                 : div_rsp.quo[16:0];
    end

    // ------------------------------------------------------------------
    // Output datapath: per-frame mode, fit difference and final value.
    // With a peak, the chunk is fitted from the previous tail before it, held
    // to the limit by the peak's gain up to the crossing, then gained by the held
    // peak; with no peak, by the held peak above the limit, else by the plain gain.
    // ------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            s_rd[c] = $signed(ram_rdata[c*sls_pkg::SAMPLE_WIDTH +: sls_pkg::SAMPLE_WIDTH]);
            if (r_pp_vld[c]) begin
                if (r_i < r_pp[c]) begin
                    m_sel[c] = sls_pkg::MODE_FIT;
                end else if (!r_cp_vld[c] || (r_i < r_cp[c])) begin
                    m_sel[c] = sls_pkg::MODE_KP;
                end else begin
                    m_sel[c] = sls_pkg::MODE_KC;
                end
            end else if (r_held[c] > 32'(bound)) begin
                m_sel[c] = sls_pkg::MODE_KC;
            end else begin
                m_sel[c] = sls_pkg::MODE_GAIN;
            end
            d_fit[c] = sls_pkg::D_W'(r_pg[c]) - (sls_pkg::D_W'(r_tail[c]) <<< 8);
            f_out[c] = fin_value(r_mode[c], r_pk[c], r_pg[c], r_pl[c], r_ph[c], r_tail[c]);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            sls_pkg::S_IDLE: begin
                if (chunk_end) begin
                    n_state = sls_pkg::S_PRE_RD;
                end
            end
            sls_pkg::S_PRE_RD: n_state = sls_pkg::S_PRE_L;
            sls_pkg::S_PRE_L:  n_state = sls_pkg::S_PRE_R;
            sls_pkg::S_PRE_R:  n_state = sls_pkg::S_DIV_LOAD;
            sls_pkg::S_DIV_LOAD: begin
                if (j_need) begin
                    n_state = sls_pkg::S_DIV_RUN;
                end else if (j_last) begin
                    n_state = sls_pkg::S_RD;
                end
            end
            sls_pkg::S_DIV_RUN: begin
                if (div_rsp.done) begin
                    n_state = j_last ? sls_pkg::S_RD : sls_pkg::S_DIV_LOAD;
                end
            end
            sls_pkg::S_RD:   n_state = sls_pkg::S_MUL1;
            sls_pkg::S_MUL1: n_state = sls_pkg::S_MUL2;
            sls_pkg::S_MUL2: n_state = sls_pkg::S_FIN;
            sls_pkg::S_FIN:  n_state = sls_pkg::S_OUT;
            sls_pkg::S_OUT: begin
                if (out_acc) begin
                    n_state = r_out_last ? sls_pkg::S_IDLE : sls_pkg::S_RD;
                end
            end
            default: n_state = sls_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        i_in.ready    = (r_state == sls_pkg::S_IDLE);
        o_out.valid   = (r_state == sls_pkg::S_OUT);
        ram_we        = frame_acc;
        case (r_state)
            sls_pkg::S_PRE_RD: ram_raddr = r_pp[0];
            sls_pkg::S_PRE_L:  ram_raddr = r_pp[1];
            default:           ram_raddr = r_i;
        endcase
    end

    assign o_out.left_out  = r_out[0];
    assign o_out.right_out = r_out[1];
    assign o_out.last_out  = r_out_last;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sls_pkg::S_IDLE;
            r_cnt      <= '0;
            r_i        <= '0;
            r_job      <= sls_pkg::JOB_KC;
            r_jch      <= 1'b0;
            r_gain[0]  <= 16'd256;
            r_gain[1]  <= 16'd256;
            r_limit    <= 15'd32767;
            r_rel      <= 16'd22726;
            for (int c = 0; c < 2; c++) begin
                r_held[c]   <= '0;
                r_local[c]  <= '0;
                r_pp_vld[c] <= 1'b0;
                r_cp_vld[c] <= 1'b0;
                r_prev[c]   <= sls_pkg::SIGN_NONE;
                r_tail[c]   <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sls_pkg::CFG_GAIN_L:  r_gain[0] <= i_cfg_data;
                    sls_pkg::CFG_GAIN_R:  r_gain[1] <= i_cfg_data;
                    sls_pkg::CFG_LIMIT:   r_limit   <= i_cfg_data[14:0];
                    sls_pkg::CFG_RELEASE: r_rel     <= i_cfg_data;
                    default: ;
                endcase
            end

            if (cmd_acc) begin
                r_cnt <= '0;
                for (int c = 0; c < 2; c++) begin
                    if (r_held[c] > 32'(bound)) begin
                        r_held[c] <= 32'(bound);
                    end
                    r_tail[c] <= '0;
                end
            end

            if (frame_acc) begin
                r_cnt <= cnt_nx;
                for (int c = 0; c < 2; c++) begin
                    r_local[c]  <= sc_local[c];
                    r_held[c]   <= sc_held[c];
                    r_pp_vld[c] <= b_pp_vld[c] | sc_pp_set[c];
                    if (sc_pp_set[c]) begin
                        r_pp[c] <= idx;
                    end
                    r_cp_vld[c] <= b_cp_vld[c] | sc_cp_set[c];
                    if (sc_cp_set[c]) begin
                        r_cp[c] <= idx;
                    end
                    r_prev[c] <= sg[c];
                end
            end

            case (r_state)
                sls_pkg::S_PRE_L: begin
                    r_sp[0] <= (s_rd[0] == '0) ? sls_pkg::SAMPLE_WIDTH'(1) :
                               (s_rd[0][sls_pkg::SAMPLE_WIDTH-1] ?
                                sls_pkg::SAMPLE_WIDTH'(-s_rd[0]) :
                                sls_pkg::SAMPLE_WIDTH'(s_rd[0]));
                end
                sls_pkg::S_PRE_R: begin
                    r_sp[1] <= (s_rd[1] == '0) ? sls_pkg::SAMPLE_WIDTH'(1) :
                               (s_rd[1][sls_pkg::SAMPLE_WIDTH-1] ?
                                sls_pkg::SAMPLE_WIDTH'(-s_rd[1]) :
                                sls_pkg::SAMPLE_WIDTH'(s_rd[1]));
                    r_job <= sls_pkg::JOB_KC;
                    r_jch <= 1'b0;
                    r_i   <= '0;
                end
                sls_pkg::S_MUL1: begin
                    for (int c = 0; c < 2; c++) begin
                        r_mode[c] <= m_sel[c];
                        r_pk[c]   <= s_rd[c] * $signed({1'b0, (m_sel[c] == sls_pkg::MODE_KP) ?
                                                              r_kp[c] : r_kc[c]});
                        r_pg[c]   <= s_rd[c] * $signed({1'b0, r_gain[c]});
                    end
                end
                sls_pkg::S_MUL2: begin
                    for (int c = 0; c < 2; c++) begin
                        r_pl[c] <= r_a[c] * $signed({1'b0, d_fit[c][23:0]});
                        r_ph[c] <= r_a[c] * $signed(d_fit[c][sls_pkg::D_W-1:24]);
                    end
                end
                sls_pkg::S_FIN: begin
                    r_out[0]   <= f_out[0];
                    r_out[1]   <= f_out[1];
                    r_out_last <= last_i;
                    if (last_i) begin
                        // The chunk's last word becomes the tail, and held
                        // peaks above the limit decay by one release step.
                        for (int c = 0; c < 2; c++) begin
                            r_tail[c] <= f_out[c];
                            if (r_held[c] > 32'(bound)) begin
                                r_held[c] <= (r_held[c] > 32'(r_rel)) ?
                                             (r_held[c] - 32'(r_rel)) : '0;
                            end
                        end
                    end
                end
                sls_pkg::S_OUT: begin
                    if (out_acc) begin
                        if (r_out_last) begin
                            r_cnt <= '0;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            if (j_adv) begin
                case (r_job)
                    sls_pkg::JOB_KC: begin
                        r_kc[r_jch] <= j_need ? q_k : '0;
                        r_job       <= sls_pkg::JOB_KP;
                    end
                    sls_pkg::JOB_KP: begin
                        r_kp[r_jch] <= j_need ? q_k : '0;
                        r_job       <= sls_pkg::JOB_FIT;
                    end
                    default: begin
                        if (!j_need) begin
                            r_a[r_jch] <= '0;
                        end else if (j_neg) begin
                            r_a[r_jch] <= -$signed({1'b0, q_a});
                        end else begin
                            r_a[r_jch] <= $signed({1'b0, q_a});
                        end
                        r_job <= sls_pkg::JOB_KC;
                        r_jch <= 1'b1;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame RAM and shared divider
    // ------------------------------------------------------------------
    sls_ram #(
        .WIDTH (2 * sls_pkg::SAMPLE_WIDTH),
        .DEPTH (sls_pkg::FRAME_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx),
        .i_wdata ({i_in.right_sample, i_in.left_sample}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

`ifndef SYNTH
    // Input and output never stand open together.
    a_in_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while a result is offered");

    // The frame count never passes the RAM depth.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= sls_pkg::CNT_W'(sls_pkg::FRAME_DEPTH))
        else $error("frame count beyond RAM depth");

    // Handing over the chunk's last word empties the chunk.
    a_chunk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_out) |=> (r_cnt == '0))
        else $error("chunk not cleared after its last word");

    // A frame marked last closes the chunk at once.
    a_chunk_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.command && i_in.last_frame)
        |=> (r_state == sls_pkg::S_PRE_RD))
        else $error("chunk did not close on a last frame");
`endif

endmodule
